### design/v4a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4a_pkg
// Shared types, constants and helpers for the four-lane fixed-point vector ALU.
// ----------------------------------------------------------------------------
package v4a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int WIDE_W    = PROD_W + 2;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DEN_W     = DATA_W + 1;
  localparam int LANES     = 4;
  localparam int SQ_STEPS  = DATA_W;
  localparam int FRONT_LAT = 4;
  // front, square root steps, rounding, divisor select, divide steps, output
  localparam int TOTAL_LAT = FRONT_LAT + SQ_STEPS + 1 + 1 + NUM_W + 1;

  localparam logic signed [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [WIDE_W-1:0] HALF_W = WIDE_W'(1) << (FRAC_BITS - 1);
  localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(1) << (DATA_W - 1);
  localparam logic [NUM_W-1:0] Q_POS_LIM = Q_NEG_LIM - NUM_W'(1);

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_SCALE    = 4'd4,
    OP_DSCALE   = 4'd5,
    OP_DOT      = 4'd6,
    OP_LENGTH   = 4'd7,
    OP_NORM     = 4'd8,
    OP_NORM_LEN = 4'd9
  } op_e;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic [LANES-1:0][DATA_W-1:0] vec_t;

  typedef struct packed {
    logic [3:0] opcode;
    fx_t        a_x;
    fx_t        a_y;
    fx_t        a_z;
    fx_t        a_w;
    fx_t        b_x;
    fx_t        b_y;
    fx_t        b_z;
    fx_t        b_w;
    fx_t        scalar_in;
  } in_t;

  typedef struct packed {
    fx_t  r_x;
    fx_t  r_y;
    fx_t  r_z;
    fx_t  r_w;
    fx_t  r_scalar;
    logic div_zero;
    logic saturated;
  } out_t;

  // item state between the front end and the divisor select
  typedef struct packed {
    logic [3:0] op;
    vec_t       a;
    vec_t       b;
    fx_t        sc;
    vec_t       r;
    fx_t        rs;
    logic       sat;
    logic       carry;
  } mid_t;

  // item state that rides beside the divide lanes
  typedef struct packed {
    logic [LANES-1:0] use_div;
    vec_t             r;
    fx_t              rs;
    logic             dz;
    logic             sat;
  } tail_t;

  typedef struct packed {
    logic [DATA_W-1:0] num;
    logic [DEN_W-1:0]  den;
    logic              neg;
  } div_in_t;

  typedef struct packed {
    fx_t  val;
    logic sat;
  } div_out_t;

  // clip to the signed 32-bit range, returns {saturated, value}
  function automatic logic [DATA_W:0] fx_clip(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(FX_MAX);
    lo = WIDE_W'(FX_MIN);
    if (v > hi) begin
      return {1'b1, FX_MAX};
    end
    if (v < lo) begin
      return {1'b1, FX_MIN};
    end
    return {1'b0, v[DATA_W-1:0]};
  endfunction

  // magnitude of a signed lane value, one bit wider
  function automatic logic [DEN_W-1:0] fx_mag(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] m;
    m = ~v + 1'b1;
    return v[DATA_W-1] ? {1'b0, m} : {1'b0, v};
  endfunction

endpackage

### design/v4a_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4a_front
// Four-stage front end: lane multipliers, add/sub, rounding, product sum.
// ----------------------------------------------------------------------------
module v4a_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  v4a_pkg::in_t                in_data,
  output logic                        out_vld,
  output v4a_pkg::mid_t               out_mid,
  output logic [v4a_pkg::PROD_W-1:0]  out_rad
);

  logic [3:0] vld_r;

  v4a_pkg::mid_t s1_r, s1_nxt;
  v4a_pkg::mid_t s2_r, s2_nxt;
  v4a_pkg::mid_t s3_r;
  v4a_pkg::mid_t s4_r, s4_nxt;

  logic signed [v4a_pkg::PROD_W-1:0] p_r   [v4a_pkg::LANES];
  logic signed [v4a_pkg::PROD_W-1:0] p_nxt [v4a_pkg::LANES];
  logic signed [v4a_pkg::PROD_W:0]   q0_r, q0_nxt, q1_r, q1_nxt;
  logic signed [v4a_pkg::WIDE_W-1:0] sum_r, sum_nxt;
  logic [v4a_pkg::PROD_W-1:0]        rad_r;

  // stage 1: operand select, multiply, add/sub
  always_comb begin
    logic [v4a_pkg::DATA_W-1:0] av, bv, opb;
    logic signed [v4a_pkg::DATA_W:0] s;
    logic [v4a_pkg::DATA_W:0] c;
    s1_nxt = '0;
    s1_nxt.op = in_data.opcode;
    s1_nxt.a = {in_data.a_w, in_data.a_z, in_data.a_y, in_data.a_x};
    s1_nxt.b = {in_data.b_w, in_data.b_z, in_data.b_y, in_data.b_x};
    s1_nxt.sc = in_data.scalar_in;
    for (int i = 0; i < v4a_pkg::LANES; i++) begin
      av = s1_nxt.a[i];
      bv = s1_nxt.b[i];
      if (in_data.opcode == v4a_pkg::OP_SCALE) begin
        opb = in_data.scalar_in;
      end else if (in_data.opcode == v4a_pkg::OP_LENGTH ||
                   in_data.opcode == v4a_pkg::OP_NORM) begin
        opb = av;
      end else begin
        opb = bv;
      end
      p_nxt[i] = v4a_pkg::PROD_W'($signed(av)) * v4a_pkg::PROD_W'($signed(opb));
      if (in_data.opcode == v4a_pkg::OP_SUB) begin
        s = $signed(av) - $signed(bv);
      end else begin
        s = $signed(av) + $signed(bv);
      end
      c = v4a_pkg::fx_clip(v4a_pkg::WIDE_W'(s));
      if (in_data.opcode == v4a_pkg::OP_ADD || in_data.opcode == v4a_pkg::OP_SUB) begin
        s1_nxt.r[i] = c[v4a_pkg::DATA_W-1:0];
        s1_nxt.sat = s1_nxt.sat | c[v4a_pkg::DATA_W];
      end
    end
  end

  // stage 2: round lane products, pairwise sums
  always_comb begin
    logic signed [v4a_pkg::WIDE_W-1:0] v, t;
    logic [v4a_pkg::DATA_W:0] c;
    s2_nxt = s1_r;
    for (int i = 0; i < v4a_pkg::LANES; i++) begin
      v = v4a_pkg::WIDE_W'(p_r[i]) + $signed(v4a_pkg::HALF_W);
      t = v >>> v4a_pkg::FRAC_BITS;
      c = v4a_pkg::fx_clip(t);
      if (s1_r.op == v4a_pkg::OP_MUL || s1_r.op == v4a_pkg::OP_SCALE) begin
        s2_nxt.r[i] = c[v4a_pkg::DATA_W-1:0];
        s2_nxt.sat = s2_nxt.sat | c[v4a_pkg::DATA_W];
      end
    end
    q0_nxt = (v4a_pkg::PROD_W+1)'(p_r[0]) + (v4a_pkg::PROD_W+1)'(p_r[1]);
    q1_nxt = (v4a_pkg::PROD_W+1)'(p_r[2]) + (v4a_pkg::PROD_W+1)'(p_r[3]);
  end

  assign sum_nxt = v4a_pkg::WIDE_W'(q0_r) + v4a_pkg::WIDE_W'(q1_r);

  // stage 4: dot product rounding, radicand for the length
  always_comb begin
    logic signed [v4a_pkg::WIDE_W-1:0] v, t;
    logic [v4a_pkg::DATA_W:0] c;
    s4_nxt = s3_r;
    v = sum_r + $signed(v4a_pkg::HALF_W);
    t = v >>> v4a_pkg::FRAC_BITS;
    c = v4a_pkg::fx_clip(t);
    if (s3_r.op == v4a_pkg::OP_DOT) begin
      s4_nxt.rs = c[v4a_pkg::DATA_W-1:0];
      s4_nxt.sat = s3_r.sat | c[v4a_pkg::DATA_W];
    end
    s4_nxt.carry = sum_r[v4a_pkg::PROD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    for (int i = 0; i < v4a_pkg::LANES; i++) begin
      p_r[i] <= p_nxt[i];
    end
    s2_r  <= s2_nxt;
    q0_r  <= q0_nxt;
    q1_r  <= q1_nxt;
    s3_r  <= s2_r;
    sum_r <= sum_nxt;
    s4_r  <= s4_nxt;
    rad_r <= sum_r[v4a_pkg::PROD_W-1:0];
  end

  assign out_vld = vld_r[3];
  assign out_mid = s4_r;
  assign out_rad = rad_r;

endmodule

### design/v4a_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4a_sqrt
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module v4a_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  v4a_pkg::mid_t               in_mid,
  input  logic [v4a_pkg::PROD_W-1:0]  in_rad,
  output logic                        out_vld,
  output v4a_pkg::mid_t               out_mid,
  output logic [v4a_pkg::DEN_W-1:0]   out_len
);

  typedef struct packed {
    logic [v4a_pkg::DATA_W-1:0] root;
    logic [v4a_pkg::DATA_W:0]   rem;
    logic [v4a_pkg::PROD_W-1:0] rad;
  } sq_t;

  sq_t                    st_r   [v4a_pkg::SQ_STEPS];
  sq_t                    st_nxt [v4a_pkg::SQ_STEPS];
  sq_t                    prv    [v4a_pkg::SQ_STEPS];
  v4a_pkg::mid_t          md_r   [v4a_pkg::SQ_STEPS];
  logic [v4a_pkg::SQ_STEPS-1:0] vld_r;

  logic                       rnd_vld_r;
  v4a_pkg::mid_t              rnd_mid_r;
  logic [v4a_pkg::DEN_W-1:0]  len_r, len_nxt;

  always_comb begin
    logic [v4a_pkg::DATA_W+2:0] rem2, trial, diff;
    prv[0] = '{root: '0, rem: '0, rad: in_rad};
    for (int k = 1; k < v4a_pkg::SQ_STEPS; k++) begin
      prv[k] = st_r[k-1];
    end
    for (int k = 0; k < v4a_pkg::SQ_STEPS; k++) begin
      rem2  = {prv[k].rem, prv[k].rad[v4a_pkg::PROD_W-1 -: 2]};
      trial = {1'b0, prv[k].root, 2'b01};
      diff  = rem2 - trial;
      st_nxt[k].rad = prv[k].rad << 2;
      if (rem2 >= trial) begin
        st_nxt[k].rem  = diff[v4a_pkg::DATA_W:0];
        st_nxt[k].root = {prv[k].root[v4a_pkg::DATA_W-2:0], 1'b1};
      end else begin
        st_nxt[k].rem  = rem2[v4a_pkg::DATA_W:0];
        st_nxt[k].root = {prv[k].root[v4a_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  // round up when the remainder exceeds the root; a sum of squares past 64 bits
  // gives exactly 2^32
  always_comb begin
    sq_t last;
    last = st_r[v4a_pkg::SQ_STEPS-1];
    if (md_r[v4a_pkg::SQ_STEPS-1].carry) begin
      len_nxt = {1'b1, {v4a_pkg::DATA_W{1'b0}}};
    end else begin
      len_nxt = {1'b0, last.root} + v4a_pkg::DEN_W'(last.rem > {1'b0, last.root});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rnd_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[v4a_pkg::SQ_STEPS-2:0], in_vld};
      rnd_vld_r <= vld_r[v4a_pkg::SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < v4a_pkg::SQ_STEPS; k++) begin
      st_r[k] <= st_nxt[k];
    end
    md_r[0] <= in_mid;
    for (int k = 1; k < v4a_pkg::SQ_STEPS; k++) begin
      md_r[k] <= md_r[k-1];
    end
    rnd_mid_r <= md_r[v4a_pkg::SQ_STEPS-1];
    len_r     <= len_nxt;
  end

  assign out_vld = rnd_vld_r;
  assign out_mid = rnd_mid_r;
  assign out_len = len_r;

endmodule

### design/v4a_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4a_div
// One divide lane: restoring division, one quotient bit per stage, then
// sign and clip. The quotient is truncated toward zero.
// ----------------------------------------------------------------------------
module v4a_div (
  input  logic                clk,
  input  v4a_pkg::div_in_t    din,
  output v4a_pkg::div_out_t   dres
);

  typedef struct packed {
    logic [v4a_pkg::DEN_W-1:0] rem;
    logic [v4a_pkg::NUM_W-1:0] numq;
    logic [v4a_pkg::DEN_W-1:0] den;
    logic                      neg;
  } dstep_t;

  dstep_t st_r   [v4a_pkg::NUM_W];
  dstep_t st_nxt [v4a_pkg::NUM_W];
  dstep_t prv    [v4a_pkg::NUM_W];

  always_comb begin
    logic [v4a_pkg::DEN_W:0] t, diff;
    logic ge;
    prv[0] = '{rem: '0, numq: {din.num, {v4a_pkg::FRAC_BITS{1'b0}}},
               den: din.den, neg: din.neg};
    for (int k = 1; k < v4a_pkg::NUM_W; k++) begin
      prv[k] = st_r[k-1];
    end
    for (int k = 0; k < v4a_pkg::NUM_W; k++) begin
      t    = {prv[k].rem, prv[k].numq[v4a_pkg::NUM_W-1]};
      diff = t - {1'b0, prv[k].den};
      ge   = (t >= {1'b0, prv[k].den});
      st_nxt[k].den  = prv[k].den;
      st_nxt[k].neg  = prv[k].neg;
      st_nxt[k].numq = {prv[k].numq[v4a_pkg::NUM_W-2:0], ge};
      st_nxt[k].rem  = ge ? diff[v4a_pkg::DEN_W-1:0] : t[v4a_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < v4a_pkg::NUM_W; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  always_comb begin
    logic [v4a_pkg::NUM_W-1:0]  q;
    logic [v4a_pkg::DATA_W-1:0] qn;
    q  = st_r[v4a_pkg::NUM_W-1].numq;
    qn = ~q[v4a_pkg::DATA_W-1:0] + 1'b1;
    if (st_r[v4a_pkg::NUM_W-1].neg) begin
      if (q > v4a_pkg::Q_NEG_LIM) begin
        dres = '{val: v4a_pkg::FX_MIN, sat: 1'b1};
      end else begin
        dres = '{val: qn, sat: 1'b0};
      end
    end else begin
      if (q > v4a_pkg::Q_POS_LIM) begin
        dres = '{val: v4a_pkg::FX_MAX, sat: 1'b1};
      end else begin
        dres = '{val: q[v4a_pkg::DATA_W-1:0], sat: 1'b0};
      end
    end
  end

endmodule

### design/vec4_fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_fixed_point_alu
// Four-lane Q16.16 vector ALU: add, sub, mul, div, scale, divide by scalar,
// dot product, length and normalize, with saturation.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and busy stays low. Each item
// comes out as a one-cycle strobe on out_valid, in the order taken, whatever
// the opcode. Each item passes through the chain: four front-end stages
// (multiply, round, two-level product sum), the 32-step square root plus
// rounding, a divisor-select stage, the 48-step divide lanes and the output
// register. Results cannot be held off.
module vec4_fixed_point_alu (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  v4a_pkg::in_t   in_data,
  output logic           out_valid,
  output v4a_pkg::out_t  out_data
);

  logic                             in_vld;
  logic                             fr_vld;
  v4a_pkg::mid_t                    fr_mid;
  logic [v4a_pkg::PROD_W-1:0]       fr_rad;
  logic                             sq_vld;
  v4a_pkg::mid_t                    sq_mid;
  logic [v4a_pkg::DEN_W-1:0]        sq_len;

  logic                             ent_vld_r;
  v4a_pkg::tail_t                   ent_r, ent_nxt;
  v4a_pkg::div_in_t                 din_r   [v4a_pkg::LANES];
  v4a_pkg::div_in_t                 din_nxt [v4a_pkg::LANES];
  v4a_pkg::div_out_t                dres    [v4a_pkg::LANES];

  v4a_pkg::tail_t                   dl_r [v4a_pkg::NUM_W];
  logic [v4a_pkg::NUM_W-1:0]        dlv_r;

  logic                             out_vld_r;
  v4a_pkg::out_t                    out_r, out_nxt;

  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  v4a_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_data (in_data),
    .out_vld (fr_vld),
    .out_mid (fr_mid),
    .out_rad (fr_rad)
  );

  v4a_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .in_mid  (fr_mid),
    .in_rad  (fr_rad),
    .out_vld (sq_vld),
    .out_mid (sq_mid),
    .out_len (sq_len)
  );

  // divisor select per lane; zero divisors are settled here
  always_comb begin
    logic [v4a_pkg::DATA_W-1:0] av, bv;
    logic a_neg;
    logic len_big;
    ent_nxt = '0;
    ent_nxt.r   = sq_mid.r;
    ent_nxt.rs  = sq_mid.rs;
    ent_nxt.sat = sq_mid.sat;
    len_big = sq_len > {1'b0, v4a_pkg::FX_MAX};
    if (sq_mid.op == v4a_pkg::OP_LENGTH) begin
      ent_nxt.rs  = len_big ? v4a_pkg::FX_MAX : sq_len[v4a_pkg::DATA_W-1:0];
      ent_nxt.sat = sq_mid.sat | len_big;
    end
    for (int i = 0; i < v4a_pkg::LANES; i++) begin
      av = sq_mid.a[i];
      bv = sq_mid.b[i];
      a_neg = av[v4a_pkg::DATA_W-1];
      din_nxt[i].num = v4a_pkg::DATA_W'(v4a_pkg::fx_mag(av));
      din_nxt[i].den = '0;
      din_nxt[i].neg = a_neg;
      unique case (sq_mid.op)
        v4a_pkg::OP_DIV: begin
          din_nxt[i].den = v4a_pkg::fx_mag(bv);
          din_nxt[i].neg = a_neg ^ bv[v4a_pkg::DATA_W-1];
          if (bv == '0) begin
            ent_nxt.r[i] = a_neg ? v4a_pkg::FX_MIN : v4a_pkg::FX_MAX;
            ent_nxt.dz   = 1'b1;
          end else begin
            ent_nxt.use_div[i] = 1'b1;
          end
        end
        v4a_pkg::OP_DSCALE, v4a_pkg::OP_NORM_LEN: begin
          din_nxt[i].den = v4a_pkg::fx_mag(sq_mid.sc);
          din_nxt[i].neg = a_neg ^ sq_mid.sc[v4a_pkg::DATA_W-1];
          ent_nxt.use_div[i] = (sq_mid.sc != '0);
        end
        v4a_pkg::OP_NORM: begin
          din_nxt[i].den = sq_len;
          ent_nxt.use_div[i] = (sq_len != '0);
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < v4a_pkg::LANES; g++) begin : g_lane
    v4a_div u_div (
      .clk  (clk),
      .din  (din_r[g]),
      .dres (dres[g])
    );
  end

  always_comb begin
    v4a_pkg::tail_t tl;
    v4a_pkg::vec_t rv;
    logic sat;
    tl  = dl_r[v4a_pkg::NUM_W-1];
    sat = tl.sat;
    for (int i = 0; i < v4a_pkg::LANES; i++) begin
      rv[i] = tl.use_div[i] ? dres[i].val : tl.r[i];
      sat   = sat | (tl.use_div[i] & dres[i].sat);
    end
    out_nxt.r_x       = rv[0];
    out_nxt.r_y       = rv[1];
    out_nxt.r_z       = rv[2];
    out_nxt.r_w       = rv[3];
    out_nxt.r_scalar  = tl.rs;
    out_nxt.div_zero  = tl.dz;
    out_nxt.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      dlv_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      ent_vld_r <= sq_vld;
      dlv_r     <= {dlv_r[v4a_pkg::NUM_W-2:0], ent_vld_r};
      out_vld_r <= dlv_r[v4a_pkg::NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    for (int i = 0; i < v4a_pkg::LANES; i++) begin
      din_r[i] <= din_nxt[i];
    end
    dl_r[0] <= ent_r;
    for (int k = 1; k < v4a_pkg::NUM_W; k++) begin
      dl_r[k] <= dl_r[k-1];
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld, v4a_pkg::TOTAL_LAT))
    else $error("result without a matching item");

  a_item_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> ##(v4a_pkg::TOTAL_LAT) out_valid)
    else $error("item lost in the pipeline");

  a_dz_no_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_zero) |-> (out_data.r_scalar == '0))
    else $error("divide by zero with a scalar result");
`endif

endmodule
